### src/nta_pkg.sv
`default_nettype none

package nta_pkg;

   // Table geometry
   localparam int TABLE_DEPTH = 8;
   localparam int IDX_W       = $clog2(TABLE_DEPTH);
   localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

   // Configuration register indexes
   localparam int CSR_IDX_W = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_OWN_NODE_ID    = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_EXPIRY_TIMEOUT = 1'd1;
   localparam logic [31:0] EXPIRY_TIMEOUT_RESET = 32'd30000;

   typedef enum logic [1:0] {
      KIND_BEACON = 2'd0,
      KIND_TICK   = 2'd1,
      KIND_UP     = 2'd2,
      KIND_DOWN   = 2'd3
   } kind_type;

   typedef enum logic [2:0] {
      ACT_NONE     = 3'd0,
      ACT_IGNORED  = 3'd1,
      ACT_UPDATED  = 3'd2,
      ACT_ADDED    = 3'd3,
      ACT_REPLACED = 3'd4
   } action_type;

   typedef enum logic [1:0] {
      CMP_MATCH  = 2'd0,
      CMP_OLDER  = 2'd1,
      CMP_EXPIRE = 2'd2
   } cmp_op_type;

   typedef struct packed {
      logic signed [7:0] signal_strength;
      logic [15:0]       rating;
      logic [7:0]        party_size;
      logic [7:0]        lead_level;
      logic [7:0]        lead_species;
   } info_type;

   typedef struct packed {
      logic [31:0] node_id;
      logic [31:0] seen;
      info_type    info;
   } entry_type;

   typedef struct packed {
      logic             we;
      logic [IDX_W-1:0] addr;
      entry_type        data;
   } wr_type;

   typedef struct packed {
      cmp_op_type  op;
      logic [31:0] a;
      logic [31:0] b;
      logic [31:0] c;
   } cmp_req_type;

   typedef struct packed {
      logic [31:0] own_node_id;
      logic [31:0] expiry_timeout;
   } cfg_type;

   typedef struct packed {
      kind_type    kind;
      logic [31:0] node_id;
      logic [31:0] time_ms;
      logic        full_length;
      info_type    info;
   } req_type;

   typedef struct packed {
      action_type  action;
      logic [3:0]  removed;
      logic [3:0]  entry_count;
      logic [2:0]  cursor_index;
      logic [31:0] cursor_node;
      info_type    info;
   } rsp_type;

endpackage

`default_nettype wire

### src/nta_channels.sv
`default_nettype none

interface nta_req_if;
   logic              valid;
   logic              ready;
   logic [1:0]        kind;
   logic [31:0]       node_id;
   logic [31:0]       time_ms;
   logic              full_length;
   logic [7:0]        lead_species;
   logic [7:0]        lead_level;
   logic [7:0]        party_size;
   logic [15:0]       rating;
   logic signed [7:0] signal_strength;

   modport source (output valid, kind, node_id, time_ms, full_length, lead_species,
                   lead_level, party_size, rating, signal_strength, input ready);
   modport sink (input valid, kind, node_id, time_ms, full_length, lead_species,
                 lead_level, party_size, rating, signal_strength, output ready);
endinterface

interface nta_rsp_if;
   logic              valid;
   logic              ready;
   logic [2:0]        action;
   logic [3:0]        removed;
   logic [3:0]        entry_count;
   logic [2:0]        cursor_index;
   logic [31:0]       cursor_node;
   logic [7:0]        cursor_species;
   logic [7:0]        cursor_level;
   logic [7:0]        cursor_party;
   logic [15:0]       cursor_rating;
   logic signed [7:0] cursor_signal;

   modport source (output valid, action, removed, entry_count, cursor_index, cursor_node,
                   cursor_species, cursor_level, cursor_party, cursor_rating,
                   cursor_signal, input ready);
   modport sink (input valid, action, removed, entry_count, cursor_index, cursor_node,
                 cursor_species, cursor_level, cursor_party, cursor_rating,
                 cursor_signal, output ready);
endinterface

`default_nettype wire

### src/nta_table.sv
`default_nettype none

module nta_table (
   input  wire logic                        clock,
   input  wire nta_pkg::wr_type             wr,
   input  wire logic [nta_pkg::IDX_W-1:0]   rd_addr,
   output nta_pkg::entry_type               rd_entry
);

   nta_pkg::entry_type mem_ff [nta_pkg::TABLE_DEPTH];

   // Write one entry per cycle
   always_ff @(posedge clock) begin
      if (wr.we) begin
         mem_ff[wr.addr] <= wr.data;
      end
   end

   // Single read port at the sequencer's index
   assign rd_entry = mem_ff[rd_addr];

endmodule

`default_nettype wire

### src/nta_cmp_unit.sv
`default_nettype none

module nta_cmp_unit (
   input  wire nta_pkg::cmp_req_type cmp_req,
   output logic                      flag
);

   logic [31:0] diff;

   // Wrapped difference for the age check
   assign diff = cmp_req.a - cmp_req.b;

   // Select the comparison for the current step
   always_comb begin
      case (cmp_req.op)
         nta_pkg::CMP_MATCH:  flag = (cmp_req.a == cmp_req.b);
         nta_pkg::CMP_OLDER:  flag = (cmp_req.a < cmp_req.b);
         nta_pkg::CMP_EXPIRE: flag = (diff > cmp_req.c);
         default:             flag = 1'b0;
      endcase
   end

endmodule

`default_nettype wire

### src/nta_seq.sv
`default_nettype none

module nta_seq (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire nta_pkg::cfg_type            cfg,
   input  wire logic                        req_valid,
   output logic                             req_ready,
   input  wire nta_pkg::req_type            req_item,
   output logic                             rsp_valid,
   input  wire logic                        rsp_ready,
   output nta_pkg::rsp_type                 rsp_item,
   output logic [nta_pkg::IDX_W-1:0]        rd_addr,
   input  wire nta_pkg::entry_type          rd_entry,
   output nta_pkg::wr_type                  wr,
   output nta_pkg::cmp_req_type             cmp_req,
   input  wire logic                        cmp_flag
);

   localparam int IDX_W = nta_pkg::IDX_W;
   localparam int CNT_W = nta_pkg::CNT_W;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_MIN,
      ST_WRITE,
      ST_EXPIRE,
      ST_CURSOR
   } state_type;

   state_type            state_ff, state_in;
   logic [IDX_W-1:0]     idx_ff, idx_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic [IDX_W-1:0]     pos_ff, pos_in;
   logic [CNT_W-1:0]     wptr_ff, wptr_in;
   logic [CNT_W-1:0]     removed_ff, removed_in;
   logic [31:0]          best_ff, best_in;
   logic [IDX_W-1:0]     slot_ff, slot_in;
   nta_pkg::action_type  action_ff, action_in;
   nta_pkg::req_type     item_ff, item_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   nta_pkg::rsp_type     rsp_ff, rsp_in;
   logic                 last_rd;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;
   assign rd_addr   = idx_ff;
   assign last_rd   = ((CNT_W'(idx_ff) + CNT_W'(1)) == cnt_ff);

   // Sequence one item through scan, oldest-entry search, write, compaction and cursor read
   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      cnt_in       = cnt_ff;
      pos_in       = pos_ff;
      wptr_in      = wptr_ff;
      removed_in   = removed_ff;
      best_in      = best_ff;
      slot_in      = slot_ff;
      action_in    = action_ff;
      item_in      = item_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      wr           = '0;
      cmp_req.op   = nta_pkg::CMP_MATCH;
      cmp_req.a    = '0;
      cmp_req.b    = '0;
      cmp_req.c    = '0;

      // Drop the result once the sink takes it
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               item_in    = req_item;
               idx_in     = '0;
               wptr_in    = '0;
               removed_in = '0;
               best_in    = '1;
               slot_in    = '0;
               action_in  = nta_pkg::ACT_NONE;
               case (req_item.kind)
                  nta_pkg::KIND_BEACON: begin
                     if (!req_item.full_length || req_item.node_id == cfg.own_node_id) begin
                        action_in = nta_pkg::ACT_IGNORED;
                        idx_in    = pos_ff;
                        state_in  = ST_CURSOR;
                     end else if (cnt_ff == '0) begin
                        action_in = nta_pkg::ACT_ADDED;
                        cnt_in    = cnt_ff + CNT_W'(1);
                        state_in  = ST_WRITE;
                     end else begin
                        state_in = ST_SCAN;
                     end
                  end
                  nta_pkg::KIND_TICK: begin
                     if (cnt_ff == '0) begin
                        idx_in   = pos_ff;
                        state_in = ST_CURSOR;
                     end else begin
                        state_in = ST_EXPIRE;
                     end
                  end
                  nta_pkg::KIND_UP: begin
                     if (cnt_ff != '0) begin
                        pos_in = (pos_ff == '0) ? IDX_W'(cnt_ff - CNT_W'(1))
                                                : pos_ff - IDX_W'(1);
                     end
                     idx_in   = pos_in;
                     state_in = ST_CURSOR;
                  end
                  nta_pkg::KIND_DOWN: begin
                     if (cnt_ff != '0) begin
                        pos_in = ((CNT_W'(pos_ff) + CNT_W'(1)) == cnt_ff) ? '0
                                                                         : pos_ff + IDX_W'(1);
                     end
                     idx_in   = pos_in;
                     state_in = ST_CURSOR;
                  end
                  default: begin
                     idx_in   = pos_ff;
                     state_in = ST_CURSOR;
                  end
               endcase
            end
         end

         // Look for an entry with the beacon's id
         ST_SCAN: begin
            cmp_req.op = nta_pkg::CMP_MATCH;
            cmp_req.a  = rd_entry.node_id;
            cmp_req.b  = item_ff.node_id;
            if (cmp_flag) begin
               slot_in   = idx_ff;
               action_in = nta_pkg::ACT_UPDATED;
               state_in  = ST_WRITE;
            end else if (last_rd) begin
               if (cnt_ff < CNT_W'(nta_pkg::TABLE_DEPTH)) begin
                  slot_in   = IDX_W'(cnt_ff);
                  cnt_in    = cnt_ff + CNT_W'(1);
                  action_in = nta_pkg::ACT_ADDED;
                  state_in  = ST_WRITE;
               end else begin
                  idx_in   = '0;
                  state_in = ST_MIN;
               end
            end else begin
               idx_in = idx_ff + IDX_W'(1);
            end
         end

         // Track the first entry with the smallest last-seen time
         ST_MIN: begin
            cmp_req.op = nta_pkg::CMP_OLDER;
            cmp_req.a  = rd_entry.seen;
            cmp_req.b  = best_ff;
            if (cmp_flag) begin
               best_in = rd_entry.seen;
               slot_in = idx_ff;
            end
            if (idx_ff == IDX_W'(nta_pkg::TABLE_DEPTH - 1)) begin
               action_in = nta_pkg::ACT_REPLACED;
               state_in  = ST_WRITE;
            end else begin
               idx_in = idx_ff + IDX_W'(1);
            end
         end

         // Store the beacon into the chosen slot
         ST_WRITE: begin
            wr.we           = 1'b1;
            wr.addr         = slot_ff;
            wr.data.node_id = item_ff.node_id;
            wr.data.seen    = item_ff.time_ms;
            wr.data.info    = item_ff.info;
            idx_in          = pos_ff;
            state_in        = ST_CURSOR;
         end

         // Drop aged entries and move survivors down in order
         ST_EXPIRE: begin
            cmp_req.op = nta_pkg::CMP_EXPIRE;
            cmp_req.a  = item_ff.time_ms;
            cmp_req.b  = rd_entry.seen;
            cmp_req.c  = cfg.expiry_timeout;
            if (cmp_flag) begin
               removed_in = removed_ff + CNT_W'(1);
            end else begin
               wr.we   = 1'b1;
               wr.addr = wptr_ff[IDX_W-1:0];
               wr.data = rd_entry;
               wptr_in = wptr_ff + CNT_W'(1);
            end
            if (last_rd) begin
               cnt_in = wptr_in;
               if (wptr_in == '0) begin
                  pos_in = '0;
               end else if (CNT_W'(pos_ff) >= wptr_in) begin
                  pos_in = IDX_W'(wptr_in - CNT_W'(1));
               end
               idx_in   = pos_in;
               state_in = ST_CURSOR;
            end else begin
               idx_in = idx_ff + IDX_W'(1);
            end
         end

         // Read the entry under the cursor and post the result
         ST_CURSOR: begin
            if (!rsp_valid_in) begin
               rsp_valid_in        = 1'b1;
               rsp_in.action       = action_ff;
               rsp_in.removed      = 4'(removed_ff);
               rsp_in.entry_count  = 4'(cnt_ff);
               rsp_in.cursor_index = 3'(pos_ff);
               if (CNT_W'(pos_ff) < cnt_ff) begin
                  rsp_in.cursor_node = rd_entry.node_id;
                  rsp_in.info        = rd_entry.info;
               end else begin
                  rsp_in.cursor_node = '0;
                  rsp_in.info        = '0;
               end
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Hold state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         pos_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         pos_ff       <= pos_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      idx_ff     <= idx_in;
      wptr_ff    <= wptr_in;
      removed_ff <= removed_in;
      best_ff    <= best_in;
      slot_ff    <= slot_in;
      action_ff  <= action_in;
      item_ff    <= item_in;
      rsp_ff     <= rsp_in;
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(nta_pkg::TABLE_DEPTH))
      else $error("entry count beyond table depth");

   a_cursor_in_table: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> (CNT_W'(pos_ff) < cnt_ff || pos_ff == '0))
      else $error("cursor outside valid entries");

   a_replace_full: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.action == nta_pkg::ACT_REPLACED)
      |-> (rsp_ff.entry_count == 4'(nta_pkg::TABLE_DEPTH)))
      else $error("replacement reported with table not full");

   a_rsp_from_cursor: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_CURSOR))
      else $error("result posted outside cursor read");

endmodule

`default_nettype wire

### src/neighbor_table_aging.sv
`default_nettype none

// Channel   Direction  Handshake        Payload
// req_chan  in         valid/ready      kind, node_id, time_ms, full_length, lead fields
// rsp_chan  out        valid/ready      action, removed, entry_count, cursor fields
// csr_*     in         csr_we only      csr_index selects own_node_id or expiry_timeout
//
// Cursor moves and ignored beacons go straight to the cursor read; a tick walks the N
// valid entries; a beacon scans them, and on a full table with no match also walks
// every entry to replace the oldest. The single table read port allows one entry to be
// scanned, compared or moved per cycle through the shared compare unit.
// Reset is synchronous and empties the table; entry contents are not cleared.
// A result waits in an output register; the next item is taken meanwhile and stalls
// only at its own result until the sink takes the earlier one.

module neighbor_table_aging (
   input  wire logic                              clock,
   input  wire logic                              reset,
   nta_req_if.sink                                req_chan,
   nta_rsp_if.source                              rsp_chan,
   input  wire logic                              csr_we,
   input  wire logic [nta_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [31:0]                       csr_wdata
);

   nta_pkg::cfg_type     cfg_ff;
   nta_pkg::req_type     req_item;
   nta_pkg::rsp_type     rsp_item;
   nta_pkg::entry_type   rd_entry;
   nta_pkg::wr_type      wr;
   nta_pkg::cmp_req_type cmp_req;
   logic [nta_pkg::IDX_W-1:0] rd_addr;
   logic                 cmp_flag;

   // Write configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.own_node_id    <= '0;
         cfg_ff.expiry_timeout <= nta_pkg::EXPIRY_TIMEOUT_RESET;
      end else if (csr_we) begin
         case (csr_index)
            nta_pkg::CSR_OWN_NODE_ID:    cfg_ff.own_node_id    <= csr_wdata;
            nta_pkg::CSR_EXPIRY_TIMEOUT: cfg_ff.expiry_timeout <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Pack the request item
   assign req_item.kind                 = nta_pkg::kind_type'(req_chan.kind);
   assign req_item.node_id              = req_chan.node_id;
   assign req_item.time_ms              = req_chan.time_ms;
   assign req_item.full_length          = req_chan.full_length;
   assign req_item.info.lead_species    = req_chan.lead_species;
   assign req_item.info.lead_level      = req_chan.lead_level;
   assign req_item.info.party_size      = req_chan.party_size;
   assign req_item.info.rating          = req_chan.rating;
   assign req_item.info.signal_strength = req_chan.signal_strength;

   // Unpack the result item
   assign rsp_chan.action         = rsp_item.action;
   assign rsp_chan.removed        = rsp_item.removed;
   assign rsp_chan.entry_count    = rsp_item.entry_count;
   assign rsp_chan.cursor_index   = rsp_item.cursor_index;
   assign rsp_chan.cursor_node    = rsp_item.cursor_node;
   assign rsp_chan.cursor_species = rsp_item.info.lead_species;
   assign rsp_chan.cursor_level   = rsp_item.info.lead_level;
   assign rsp_chan.cursor_party   = rsp_item.info.party_size;
   assign rsp_chan.cursor_rating  = rsp_item.info.rating;
   assign rsp_chan.cursor_signal  = rsp_item.info.signal_strength;

   nta_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .req_item  (req_item),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .rsp_item  (rsp_item),
      .rd_addr   (rd_addr),
      .rd_entry  (rd_entry),
      .wr        (wr),
      .cmp_req   (cmp_req),
      .cmp_flag  (cmp_flag)
   );

   nta_table u_table (
      .clock    (clock),
      .wr       (wr),
      .rd_addr  (rd_addr),
      .rd_entry (rd_entry)
   );

   nta_cmp_unit u_cmp (
      .cmp_req (cmp_req),
      .flag    (cmp_flag)
   );

endmodule

`default_nettype wire
